// ===== rtl/rwstm_pkg.sv =====
// shared types and constants for the random walk spanning tree maze block
// no dependencies; used by every module under rtl
package rwstm_pkg;

  localparam int CFG_W     = 7;   // cell_rows / cell_cols register width
  localparam int START_W   = 6;   // start_row / start_col width
  localparam int WORD_W    = 32;  // random word width
  localparam int DIR_W     = 2;   // one direction digit
  localparam int WORD_DIRS = 16;  // digits in one random word
  localparam int DCNT_W    = $clog2(WORD_DIRS + 1);
  localparam int COORD_W   = 7;   // maze grid coordinate width

  // request kinds
  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_WORD  = 1'b1;

  // direction digits
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  // register indexes (word address bit 2)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BEGIN,
    ST_LOOK,
    ST_CHECK,
    ST_FINISH
  } rwstm_state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } rwstm_map_ctl_t;

  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] passage_row;
    logic [COORD_W-1:0] passage_col;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               all_done;
    logic               last;
  } rwstm_result_t;

endpackage

// ===== rtl/rwstm_cfg.sv =====
// apb register block holding the grid size (cell_rows, cell_cols)
// depends on rwstm_pkg
module rwstm_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [rwstm_pkg::CFG_W-1:0] cell_rows,
  output logic [rwstm_pkg::CFG_W-1:0] cell_cols
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_rows <= rwstm_pkg::CFG_W'(8);
      cell_cols <= rwstm_pkg::CFG_W'(8);
    end else if (wr_en) begin
      case (paddr[2])
        rwstm_pkg::REG_ROWS: cell_rows <= pwdata[rwstm_pkg::CFG_W-1:0];
        rwstm_pkg::REG_COLS: cell_cols <= pwdata[rwstm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rwstm_pkg::REG_ROWS: prdata = 32'(cell_rows);
      rwstm_pkg::REG_COLS: prdata = 32'(cell_cols);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/rwstm_map.sv =====
// single-port visited map, one bit per cell, registered read
// depends on rwstm_pkg for the control struct
module rwstm_map #(
  parameter int AW = 12
) (
  input  logic                      clk,
  input  rwstm_pkg::rwstm_map_ctl_t ctl,
  input  logic [AW-1:0]             addr,
  output logic                      rdata
);

  localparam int DEPTH = 2 ** AW;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/rwstm_walk.sv =====
// walk sequencer: clearing sweep, direction digit shifter, walker, pending
// result and output register; depends on rwstm_pkg, drives rwstm_map
module rwstm_walk #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int RW       = 6,
  parameter int CW       = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rwstm_pkg::CFG_W-1:0]   cell_rows,
  input  logic [rwstm_pkg::CFG_W-1:0]   cell_cols,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic                          req_type,
  input  logic [rwstm_pkg::START_W-1:0] start_row,
  input  logic [rwstm_pkg::START_W-1:0] start_col,
  input  logic [rwstm_pkg::WORD_W-1:0]  random_word,
  output logic                          m_valid,
  input  logic                          m_ready,
  output rwstm_pkg::rwstm_result_t      m_res,
  output rwstm_pkg::rwstm_map_ctl_t     map_ctl,
  output logic [RW+CW-1:0]              map_addr,
  input  logic                          map_rdata
);

  localparam int SW = $clog2(MAX_ROWS + 1);
  localparam int SCW = $clog2(MAX_COLS + 1);
  localparam int TW = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int XW = RW + 1;
  localparam int YW = CW + 1;

  rwstm_pkg::rwstm_state_t state, state_next;

  logic [RW+CW-1:0]                 clr_addr;
  logic                             clr_begin;
  logic [RW-1:0]                    start_r;
  logic [CW-1:0]                    start_c;
  logic [RW-1:0]                    walker_row, prev_row, tgt_row;
  logic [CW-1:0]                    walker_col, prev_col, tgt_col;
  logic [TW-1:0]                    visited_count;
  logic [rwstm_pkg::WORD_W-1:0]     word_sr;
  logic [rwstm_pkg::DCNT_W-1:0]     dir_cnt;
  logic                             pend_valid;
  rwstm_pkg::rwstm_result_t         pend;
  logic                             out_valid;
  rwstm_pkg::rwstm_result_t         out_res;

  logic [SW-1:0]                    rows_eff, rows_m1;
  logic [SCW-1:0]                   cols_eff, cols_m1;
  logic [TW-1:0]                    total, count_inc;
  logic                             walk_done, word_end;
  logic [XW-1:0]                    nr_x;
  logic [YW-1:0]                    nc_x;
  logic                             move_ok;
  logic                             out_free, out_load, carve;
  rwstm_pkg::rwstm_result_t         out_data, new_res, begin_res, none_res;
  logic [RW-1:0]                    start_r_sat;
  logic [CW-1:0]                    start_c_sat;
  logic [XW-1:0]                    sum_r;
  logic [YW-1:0]                    sum_c;

  // effective grid size: zero counts as one, oversize clips to the maximum
  always_comb begin
    if (cell_rows == '0) begin
      rows_eff = SW'(1);
    end else if (32'(cell_rows) > 32'(MAX_ROWS)) begin
      rows_eff = SW'(MAX_ROWS);
    end else begin
      rows_eff = SW'(cell_rows);
    end
    if (cell_cols == '0) begin
      cols_eff = SCW'(1);
    end else if (32'(cell_cols) > 32'(MAX_COLS)) begin
      cols_eff = SCW'(MAX_COLS);
    end else begin
      cols_eff = SCW'(cell_cols);
    end
  end

  assign rows_m1   = rows_eff - SW'(1);
  assign cols_m1   = cols_eff - SCW'(1);
  assign total     = TW'(rows_eff) * TW'(cols_eff);
  assign count_inc = visited_count + TW'(1);
  assign walk_done = visited_count >= total;
  assign word_end  = dir_cnt == rwstm_pkg::DCNT_W'(rwstm_pkg::WORD_DIRS);

  assign start_r_sat = (32'(start_row) >= 32'(rows_eff)) ? RW'(rows_m1) : RW'(start_row);
  assign start_c_sat = (32'(start_col) >= 32'(cols_eff)) ? CW'(cols_m1) : CW'(start_col);

  // target of the current digit; a step below zero wraps high and fails the range check
  always_comb begin
    nr_x = XW'(walker_row);
    nc_x = YW'(walker_col);
    case (word_sr[rwstm_pkg::DIR_W-1:0])
      rwstm_pkg::DIR_UP:    nr_x = XW'(walker_row) - XW'(1);
      rwstm_pkg::DIR_RIGHT: nc_x = YW'(walker_col) + YW'(1);
      rwstm_pkg::DIR_DOWN:  nr_x = XW'(walker_row) + XW'(1);
      rwstm_pkg::DIR_LEFT:  nc_x = YW'(walker_col) - YW'(1);
      default: ;
    endcase
  end

  assign move_ok = (nr_x < XW'(rows_eff)) && (nc_x < YW'(cols_eff));

  assign out_free = !out_valid || m_ready;
  assign carve    = (state == rwstm_pkg::ST_CHECK) && !map_rdata && (!pend_valid || out_free);

  assign sum_r = XW'(prev_row) + XW'(tgt_row) + XW'(1);
  assign sum_c = YW'(prev_col) + YW'(tgt_col) + YW'(1);

  always_comb begin
    new_res.carved      = 1'b1;
    new_res.passage_row = rwstm_pkg::COORD_W'(sum_r);
    new_res.passage_col = rwstm_pkg::COORD_W'(sum_c);
    new_res.cell_row    = rwstm_pkg::COORD_W'({tgt_row, 1'b1});
    new_res.cell_col    = rwstm_pkg::COORD_W'({tgt_col, 1'b1});
    new_res.all_done    = count_inc >= total;
    new_res.last        = 1'b0;

    begin_res.carved      = 1'b1;
    begin_res.passage_row = rwstm_pkg::COORD_W'({start_r, 1'b1});
    begin_res.passage_col = rwstm_pkg::COORD_W'({start_c, 1'b1});
    begin_res.cell_row    = rwstm_pkg::COORD_W'({start_r, 1'b1});
    begin_res.cell_col    = rwstm_pkg::COORD_W'({start_c, 1'b1});
    begin_res.all_done    = TW'(1) >= total;
    begin_res.last        = 1'b1;

    none_res          = '0;
    none_res.all_done = walk_done;
    none_res.last     = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rwstm_pkg::ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = clr_begin ? rwstm_pkg::ST_BEGIN : rwstm_pkg::ST_IDLE;
        end
      end
      rwstm_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = (req_type == rwstm_pkg::REQ_BEGIN) ? rwstm_pkg::ST_CLEAR
                                                          : rwstm_pkg::ST_LOOK;
        end
      end
      rwstm_pkg::ST_BEGIN: begin
        if (out_free) begin
          state_next = rwstm_pkg::ST_IDLE;
        end
      end
      rwstm_pkg::ST_LOOK: begin
        if (walk_done || word_end) begin
          state_next = rwstm_pkg::ST_FINISH;
        end else if (move_ok) begin
          state_next = rwstm_pkg::ST_CHECK;
        end
      end
      rwstm_pkg::ST_CHECK: begin
        if (map_rdata || !pend_valid || out_free) begin
          state_next = rwstm_pkg::ST_LOOK;
        end
      end
      rwstm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = rwstm_pkg::ST_IDLE;
        end
      end
      default: state_next = rwstm_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_ready  = 1'b0;
    map_ctl  = '0;
    map_addr = {tgt_row, tgt_col};
    out_load = 1'b0;
    out_data = pend;
    case (state)
      rwstm_pkg::ST_CLEAR: begin
        map_ctl.wr = 1'b1;
        map_addr   = clr_addr;
      end
      rwstm_pkg::ST_IDLE: begin
        s_ready = 1'b1;
      end
      rwstm_pkg::ST_BEGIN: begin
        map_ctl.wr    = 1'b1;
        map_ctl.wdata = 1'b1;
        map_addr      = {start_r, start_c};
        out_load      = out_free;
        out_data      = begin_res;
      end
      rwstm_pkg::ST_LOOK: begin
        map_ctl.rd = !walk_done && !word_end && move_ok;
        map_addr   = {nr_x[RW-1:0], nc_x[CW-1:0]};
      end
      rwstm_pkg::ST_CHECK: begin
        map_ctl.wr    = carve;
        map_ctl.wdata = 1'b1;
        out_load      = carve && pend_valid;
      end
      rwstm_pkg::ST_FINISH: begin
        out_load = out_free;
        if (pend_valid) begin
          out_data      = pend;
          out_data.last = 1'b1;
        end else begin
          out_data = none_res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rwstm_pkg::ST_CLEAR;
      clr_addr      <= '0;
      clr_begin     <= 1'b0;
      walker_row    <= '0;
      walker_col    <= '0;
      visited_count <= '0;
      dir_cnt       <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        rwstm_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + (RW+CW)'(1);
        end
        rwstm_pkg::ST_IDLE: begin
          if (s_valid) begin
            clr_addr  <= '0;
            clr_begin <= 1'b1;
            dir_cnt   <= '0;
          end
        end
        rwstm_pkg::ST_BEGIN: begin
          if (out_free) begin
            walker_row    <= start_r;
            walker_col    <= start_c;
            visited_count <= TW'(1);
          end
        end
        rwstm_pkg::ST_LOOK: begin
          if (!walk_done && !word_end) begin
            dir_cnt <= dir_cnt + rwstm_pkg::DCNT_W'(1);
            if (move_ok) begin
              walker_row <= nr_x[RW-1:0];
              walker_col <= nc_x[CW-1:0];
            end
          end
        end
        rwstm_pkg::ST_CHECK: begin
          if (carve) begin
            visited_count <= count_inc;
            pend_valid    <= 1'b1;
          end
        end
        rwstm_pkg::ST_FINISH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == rwstm_pkg::ST_IDLE && s_valid) begin
      start_r <= start_r_sat;
      start_c <= start_c_sat;
      word_sr <= random_word;
    end
    if (state == rwstm_pkg::ST_LOOK && !walk_done && !word_end) begin
      // one direction digit per step
      word_sr <= word_sr >> rwstm_pkg::DIR_W;
      if (move_ok) begin
        prev_row <= walker_row;
        prev_col <= walker_col;
        tgt_row  <= nr_x[RW-1:0];
        tgt_col  <= nc_x[CW-1:0];
      end
    end
    if (carve) begin
      pend <= new_res;
    end
    if (out_load) begin
      out_res <= out_data;
    end
  end

  assign m_valid = out_valid;
  assign m_res   = out_res;

endmodule

// ===== rtl/random_walk_spanning_tree_maze.sv =====
// random walk (aldous-broder) spanning tree maze generator, top level
// depends on rwstm_pkg, rwstm_cfg, rwstm_map, rwstm_walk
//
//  channel  direction  beat carries
//  s_*      in         request kind in tuser, start cell and random word in tdata
//  m_*      out        passage and cell coordinates in tdata, carved/done in tuser
//  apb      in         cell_rows at 0x0, cell_cols at 0x4
//
// after reset a sweep over every map address clears the visited map before the
// first beat is taken. a begin beat repeats the sweep, then marks the start cell
// visited and emits it once the output is free. a digit leading off the grid is
// skipped; an in-grid move reads the single-port visited map, then writes it if
// the cell is unvisited. a stalled output holds any carve while a result is pending.
module random_walk_spanning_tree_maze #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // start_row[5:0], start_col[11:6], random_word[43:12]
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // passage_row[6:0], passage_col[13:7], cell_row[20:14],
                                 // cell_col[27:21]
  output logic [1:0]  m_tuser,   // carved[0], all_done[1]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [rwstm_pkg::CFG_W-1:0] cell_rows;
  logic [rwstm_pkg::CFG_W-1:0] cell_cols;
  rwstm_pkg::rwstm_result_t    res;
  rwstm_pkg::rwstm_map_ctl_t   map_ctl;
  logic [RW+CW-1:0]            map_addr;
  logic                        map_rdata;

  rwstm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cell_rows (cell_rows),
    .cell_cols (cell_cols)
  );

  rwstm_map #(
    .AW (RW + CW)
  ) u_map (
    .clk   (clk),
    .ctl   (map_ctl),
    .addr  (map_addr),
    .rdata (map_rdata)
  );

  rwstm_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .cell_rows   (cell_rows),
    .cell_cols   (cell_cols),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .req_type    (s_tuser[0]),
    .start_row   (s_tdata[5:0]),
    .start_col   (s_tdata[11:6]),
    .random_word (s_tdata[43:12]),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .m_res       (res),
    .map_ctl     (map_ctl),
    .map_addr    (map_addr),
    .map_rdata   (map_rdata)
  );

  assign m_tdata = {4'b0000, res.cell_col, res.cell_row, res.passage_col, res.passage_row};
  assign m_tuser = {res.all_done, res.carved};
  assign m_tlast = res.last;

endmodule
